FILE: hdl/qso_pkg.sv
// Shared types for the quadrature sine oscillator: serial unit operations and requests.
package qso_pkg;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } ser_op_e;

  typedef struct packed {
    logic    start;
    ser_op_e op;
  } ser_req_t;

endpackage

FILE: hdl/qso_in_if.sv
// Input channel of the oscillator: one beat per sample tick.
interface qso_in_if;
  logic        valid;
  logic        ready;
  logic [22:0] frequency;
  logic        reset_phase;

  modport source(output valid, frequency, reset_phase, input ready);
  modport sink(input valid, frequency, reset_phase, output ready);
endinterface

FILE: hdl/qso_out_if.sv
// Output channel of the oscillator: one beat per output sample.
interface qso_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample;

  modport source(output valid, sample, input ready);
  modport sink(input valid, sample, output ready);
endinterface

FILE: hdl/qso_serial.sv
// Bit-serial arithmetic unit: 64x64 multiply, 64/64 divide and 64-bit integer square root.
module qso_serial (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qso_pkg::ser_req_t req_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  output logic              done_o,
  output logic [127:0]      res_o
);
  import qso_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  ser_op_e     op_q;
  logic [63:0] hi_q;
  logic [63:0] lo_q;
  logic [63:0] ac_q;

  logic [64:0] mul_sum;
  logic [64:0] div_t;
  logic [64:0] div_r;
  logic        div_ge;
  logic [34:0] sq_t;
  logic [34:0] sq_trial;
  logic [34:0] sq_r;
  logic        sq_ge;
  logic        last;

  assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, ac_q} : 65'd0);
  assign div_t    = {hi_q, lo_q[63]};
  assign div_ge   = div_t >= {1'b0, ac_q};
  assign div_r    = div_t - {1'b0, ac_q};
  assign sq_t     = {hi_q[32:0], lo_q[63:62]};
  assign sq_trial = {1'b0, ac_q[31:0], 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_r     = sq_t - sq_trial;
  assign last     = (op_q == OP_SQRT) ? (cnt_q == 6'd31) : (cnt_q == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q <= req_i.op;
      hi_q <= '0;
      lo_q <= b_i;
      ac_q <= (req_i.op == OP_SQRT) ? 64'd0 : a_i;
    end else if (busy_q) begin
      unique case (op_q)
        OP_MUL: begin
          hi_q <= mul_sum[64:1];
          lo_q <= {mul_sum[0], lo_q[63:1]};
        end
        OP_DIV: begin
          hi_q <= div_ge ? div_r[63:0] : div_t[63:0];
          lo_q <= {lo_q[62:0], div_ge};
        end
        OP_SQRT: begin
          hi_q <= {29'd0, sq_ge ? sq_r : sq_t};
          lo_q <= {lo_q[61:0], 2'b00};
          ac_q <= {32'd0, ac_q[30:0], sq_ge};
        end
        default: begin
          hi_q <= hi_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (op_q)
      OP_MUL:  res_o = {hi_q, lo_q};
      OP_DIV:  res_o = {64'd0, lo_q};
      OP_SQRT: res_o = {96'd0, ac_q[31:0]};
      default: res_o = '0;
    endcase
  end

  assign done_o = done_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("serial unit started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("serial unit done while still busy");

  a_sqrt_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && op_q == OP_SQRT) |-> cnt_q <= 6'd31) else $error("square root ran too long");

endmodule

FILE: hdl/quadrature_sine_oscillator_core.sv
// Quadrature sine oscillator: rotates a unit phasor once per sample tick and scales its sine part.
// Each tick's frequency becomes a rotation angle through a bit-serial divider, the phasor is
// rotated by four serial multiplies and the output scaled by one more. Every arithmetic step goes
// through one shared bit-serial unit. A new angle adds a Taylor evaluation of 42 serial steps,
// priming adds a second one, and the magnitude check every RENORM_INTERVAL ticks adds a squared
// magnitude test and, when it is out of tolerance, a renormalization of the phasor.
module quadrature_sine_oscillator_core #(
  parameter int RENORM_INTERVAL = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qso_in_if.sink      item_in,
  qso_out_if.source   result_out,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [18:0] cfg_data_i
);
  import qso_pkg::*;

  localparam int CntW = $clog2(RENORM_INTERVAL + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(RENORM_INTERVAL - 1);

  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_AMP   = 2'd1;
  localparam logic [1:0] REG_PHASE = 2'd2;

  localparam logic [63:0] PiQ60  = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] OneQ60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] TolQ60 = OneQ60 / 64'd100000;
  localparam logic [63:0] MagHi  = OneQ60 + TolQ60;
  localparam logic [63:0] MagLo  = OneQ60 - TolQ60;
  localparam logic signed [31:0] OneP = 32'sh4000_0000;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_ANG  = 5'd1;
  localparam logic [4:0] ST_TTH  = 5'd2;
  localparam logic [4:0] ST_TT2  = 5'd3;
  localparam logic [4:0] ST_TMS  = 5'd4;
  localparam logic [4:0] ST_TDS  = 5'd5;
  localparam logic [4:0] ST_TMC  = 5'd6;
  localparam logic [4:0] ST_TDC  = 5'd7;
  localparam logic [4:0] ST_RXC  = 5'd8;
  localparam logic [4:0] ST_RYS  = 5'd9;
  localparam logic [4:0] ST_RXS  = 5'd10;
  localparam logic [4:0] ST_RYC  = 5'd11;
  localparam logic [4:0] ST_NXX  = 5'd12;
  localparam logic [4:0] ST_NYY  = 5'd13;
  localparam logic [4:0] ST_NSQ  = 5'd14;
  localparam logic [4:0] ST_NINV = 5'd15;
  localparam logic [4:0] ST_NMX  = 5'd16;
  localparam logic [4:0] ST_NMY  = 5'd17;
  localparam logic [4:0] ST_OMUL = 5'd18;
  localparam logic [4:0] ST_OUT  = 5'd19;

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] q60p(logic [63:0] v, logic neg);
    logic [63:0] r;
    r = (v + 64'h2000_0000) >> 30;
    q60p = neg ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  function automatic logic signed [34:0] mq_term(logic [63:0] p, logic neg);
    logic [63:0] r;
    r = (p + 64'h2000_0000) >> 30;
    mq_term = neg ? -$signed({1'b0, r[33:0]}) : $signed({1'b0, r[33:0]});
  endfunction

  function automatic logic signed [31:0] sat35(logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      sat35 = 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      sat35 = 32'sh8000_0000;
    end else begin
      sat35 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] renorm(logic [63:0] m, logic neg);
    if (neg) begin
      renorm = (m > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    end else begin
      renorm = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end
  endfunction

  function automatic logic [8:0] sin_div(logic [3:0] k);
    logic [8:0] t;
    t = {4'd0, k, 1'b0};
    sin_div = 9'(t * (t + 9'd1));
  endfunction

  function automatic logic [8:0] cos_div(logic [3:0] k);
    logic [8:0] t;
    t = {4'd0, k, 1'b0};
    cos_div = 9'((t - 9'd1) * t);
  endfunction

  logic [4:0]         st_q;
  logic               go_q;
  logic [18:0]        rate_q;
  logic [15:0]        amp_q;
  logic [15:0]        sph_q;
  logic [22:0]        freq_q;
  logic               rst_q;
  logic               primed_q;
  logic [CntW-1:0]    cnt_q;
  logic signed [31:0] x_q, y_q, rc_q, rs_q, nx_q, ny_q;
  logic [31:0]        rang_q, tang_q;
  logic               tphase_q, prime_q;
  logic [63:0]        t2_q, ss_q, cs_q, ts_q, tc_q, tmp_q, sum_q, inv_q;
  logic [3:0]         k_q;
  logic signed [34:0] acc_q;
  logic signed [23:0] samp_q, sample_q;
  logic               ov_q;

  ser_req_t      ser_req;
  logic [63:0]   ser_a, ser_b;
  logic          ser_done;
  logic [127:0]  ser_res;

  logic [18:0]        rate_eff;
  logic [63:0]        ang_div;
  logic [29:0]        tf;
  logic               tswap;
  logic [30:0]        tg;
  logic signed [31:0] pa, pb;
  logic               mneg;
  logic signed [34:0] term;
  logic [127:0]       th_sum;
  logic [63:0]        cs_n, sq_v, cq_v, nsum, om_mag;
  logic [31:0]        q;

  assign rate_eff = (rate_q <= 19'd1) ? 19'd44100 : rate_q;
  assign ang_div  = {17'd0, freq_q, 24'd0} + {46'd0, rate_eff[18:1]};
  assign tf       = tang_q[29:0];
  assign tswap    = tf >= 30'h2000_0000;
  assign tg       = tswap ? (31'h4000_0000 - {1'b0, tf}) : {1'b0, tf};
  assign q        = ser_res[31:0];
  assign th_sum   = ser_res + 128'h4000_0000;
  assign cs_n     = k_q[0] ? (cs_q - ser_res[63:0]) : (cs_q + ser_res[63:0]);
  assign sq_v     = tswap ? cs_n : ss_q;
  assign cq_v     = tswap ? ss_q : cs_n;
  assign nsum     = sum_q + ser_res[63:0];
  assign om_mag   = (ser_res[63:0] + 64'h20_0000) >> 22;

  always_comb begin
    unique case (st_q)
      ST_RYS:  begin pa = y_q; pb = rs_q; end
      ST_RXS:  begin pa = x_q; pb = rs_q; end
      ST_RYC:  begin pa = y_q; pb = rc_q; end
      default: begin pa = x_q; pb = rc_q; end
    endcase
  end

  assign mneg = pa[31] ^ pb[31];
  assign term = mq_term(ser_res[63:0], mneg);

  always_comb begin
    ser_req.start = go_q;
    ser_req.op    = OP_MUL;
    ser_a         = '0;
    ser_b         = '0;
    unique case (st_q)
      ST_ANG: begin
        ser_req.op = OP_DIV;
        ser_a      = {45'd0, rate_eff};
        ser_b      = ang_div;
      end
      ST_TTH: begin ser_a = {33'd0, tg}; ser_b = PiQ60; end
      ST_TT2: begin ser_a = ts_q; ser_b = ts_q; end
      ST_TMS: begin ser_a = ts_q; ser_b = t2_q; end
      ST_TDS: begin
        ser_req.op = OP_DIV;
        ser_a      = {55'd0, sin_div(k_q)};
        ser_b      = tmp_q;
      end
      ST_TMC: begin ser_a = tc_q; ser_b = t2_q; end
      ST_TDC: begin
        ser_req.op = OP_DIV;
        ser_a      = {55'd0, cos_div(k_q)};
        ser_b      = tmp_q;
      end
      ST_RXC, ST_RYS, ST_RXS, ST_RYC: begin
        ser_a = {32'd0, abs32(pa)};
        ser_b = {32'd0, abs32(pb)};
      end
      ST_NXX: begin ser_a = {32'd0, abs32(nx_q)}; ser_b = {32'd0, abs32(nx_q)}; end
      ST_NYY: begin ser_a = {32'd0, abs32(ny_q)}; ser_b = {32'd0, abs32(ny_q)}; end
      ST_NSQ: begin ser_req.op = OP_SQRT; ser_b = sum_q; end
      ST_NINV: begin ser_req.op = OP_DIV; ser_a = inv_q; ser_b = OneQ60; end
      ST_NMX: begin ser_a = {32'd0, abs32(nx_q)}; ser_b = inv_q; end
      ST_NMY: begin ser_a = {32'd0, abs32(ny_q)}; ser_b = inv_q; end
      ST_OMUL: begin ser_a = {32'd0, abs32(ny_q)}; ser_b = {48'd0, amp_q}; end
      default: begin ser_a = '0; end
    endcase
  end

  qso_serial u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ser_req),
    .a_i    (ser_a),
    .b_i    (ser_b),
    .done_o (ser_done),
    .res_o  (ser_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      go_q     <= 1'b0;
      rate_q   <= 19'd44100;
      amp_q    <= 16'd32768;
      sph_q    <= '0;
      freq_q   <= '0;
      rst_q    <= 1'b0;
      primed_q <= 1'b0;
      cnt_q    <= '0;
      x_q      <= OneP;
      y_q      <= '0;
      rc_q     <= OneP;
      rs_q     <= '0;
      nx_q     <= '0;
      ny_q     <= '0;
      rang_q   <= '0;
      tang_q   <= '0;
      tphase_q <= 1'b0;
      prime_q  <= 1'b0;
      t2_q     <= '0;
      ss_q     <= '0;
      cs_q     <= '0;
      ts_q     <= '0;
      tc_q     <= '0;
      tmp_q    <= '0;
      sum_q    <= '0;
      inv_q    <= '0;
      k_q      <= 4'd1;
      acc_q    <= '0;
      samp_q   <= '0;
      sample_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RATE:  rate_q <= cfg_data_i;
          REG_AMP:   amp_q <= cfg_data_i[15:0];
          REG_PHASE: sph_q <= cfg_data_i[15:0];
          default:   rate_q <= rate_q;
        endcase
      end
      if (result_out.ready) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (item_in.valid) begin
            freq_q <= item_in.frequency;
            rst_q  <= item_in.reset_phase;
            st_q   <= ST_ANG;
            go_q   <= 1'b1;
          end
        end
        ST_ANG: begin
          if (ser_done) begin
            go_q <= 1'b1;
            if (rst_q || !primed_q) begin
              rang_q   <= q;
              tang_q   <= q;
              primed_q <= 1'b1;
              cnt_q    <= '0;
              prime_q  <= 1'b1;
              tphase_q <= 1'b0;
              st_q     <= ST_TTH;
            end else if (q != rang_q) begin
              rang_q   <= q;
              tang_q   <= q;
              prime_q  <= 1'b0;
              tphase_q <= 1'b0;
              st_q     <= ST_TTH;
            end else begin
              st_q <= ST_RXC;
            end
          end
        end
        ST_TTH: begin
          if (ser_done) begin
            ts_q <= th_sum[94:31];
            ss_q <= th_sum[94:31];
            st_q <= ST_TT2;
            go_q <= 1'b1;
          end
        end
        ST_TT2: begin
          if (ser_done) begin
            t2_q <= ser_res[123:60];
            cs_q <= OneQ60;
            tc_q <= OneQ60;
            k_q  <= 4'd1;
            st_q <= ST_TMS;
            go_q <= 1'b1;
          end
        end
        ST_TMS: begin
          if (ser_done) begin
            tmp_q <= ser_res[123:60];
            st_q  <= ST_TDS;
            go_q  <= 1'b1;
          end
        end
        ST_TDS: begin
          if (ser_done) begin
            ts_q <= ser_res[63:0];
            ss_q <= k_q[0] ? (ss_q - ser_res[63:0]) : (ss_q + ser_res[63:0]);
            st_q <= ST_TMC;
            go_q <= 1'b1;
          end
        end
        ST_TMC: begin
          if (ser_done) begin
            tmp_q <= ser_res[123:60];
            st_q  <= ST_TDC;
            go_q  <= 1'b1;
          end
        end
        ST_TDC: begin
          if (ser_done) begin
            tc_q <= ser_res[63:0];
            cs_q <= cs_n;
            go_q <= 1'b1;
            if (k_q == 4'd10) begin
              if (!tphase_q) begin
                unique case (tang_q[31:30])
                  2'd0: begin rs_q <= q60p(sq_v, 1'b0); rc_q <= q60p(cq_v, 1'b0); end
                  2'd1: begin rs_q <= q60p(cq_v, 1'b0); rc_q <= q60p(sq_v, 1'b1); end
                  2'd2: begin rs_q <= q60p(sq_v, 1'b1); rc_q <= q60p(cq_v, 1'b1); end
                  default: begin rs_q <= q60p(cq_v, 1'b1); rc_q <= q60p(sq_v, 1'b0); end
                endcase
              end else begin
                unique case (tang_q[31:30])
                  2'd0: begin y_q <= q60p(sq_v, 1'b0); x_q <= q60p(cq_v, 1'b0); end
                  2'd1: begin y_q <= q60p(cq_v, 1'b0); x_q <= q60p(sq_v, 1'b1); end
                  2'd2: begin y_q <= q60p(sq_v, 1'b1); x_q <= q60p(cq_v, 1'b1); end
                  default: begin y_q <= q60p(cq_v, 1'b1); x_q <= q60p(sq_v, 1'b0); end
                endcase
              end
              if (!tphase_q && prime_q) begin
                tphase_q <= 1'b1;
                tang_q   <= {sph_q, 16'd0};
                st_q     <= ST_TTH;
              end else begin
                st_q <= ST_RXC;
              end
            end else begin
              k_q  <= k_q + 4'd1;
              st_q <= ST_TMS;
            end
          end
        end
        ST_RXC: begin
          if (ser_done) begin
            acc_q <= term;
            st_q  <= ST_RYS;
            go_q  <= 1'b1;
          end
        end
        ST_RYS: begin
          if (ser_done) begin
            nx_q <= sat35(acc_q - term);
            st_q <= ST_RXS;
            go_q <= 1'b1;
          end
        end
        ST_RXS: begin
          if (ser_done) begin
            acc_q <= term;
            st_q  <= ST_RYC;
            go_q  <= 1'b1;
          end
        end
        ST_RYC: begin
          if (ser_done) begin
            ny_q <= sat35(acc_q + term);
            go_q <= 1'b1;
            if (cnt_q == CntLast) begin
              cnt_q <= '0;
              st_q  <= ST_NXX;
            end else begin
              cnt_q <= cnt_q + 1'b1;
              st_q  <= ST_OMUL;
            end
          end
        end
        ST_NXX: begin
          if (ser_done) begin
            sum_q <= ser_res[63:0];
            st_q  <= ST_NYY;
            go_q  <= 1'b1;
          end
        end
        ST_NYY: begin
          if (ser_done) begin
            go_q <= 1'b1;
            if (nsum > MagHi || nsum < MagLo) begin
              if (nsum == 64'd0) begin
                nx_q <= OneP;
                ny_q <= '0;
                st_q <= ST_OMUL;
              end else begin
                sum_q <= nsum;
                st_q  <= ST_NSQ;
              end
            end else begin
              st_q <= ST_OMUL;
            end
          end
        end
        ST_NSQ: begin
          if (ser_done) begin
            inv_q <= {32'd0, ser_res[31:0]};
            st_q  <= ST_NINV;
            go_q  <= 1'b1;
          end
        end
        ST_NINV: begin
          if (ser_done) begin
            inv_q <= ser_res[63:0];
            st_q  <= ST_NMX;
            go_q  <= 1'b1;
          end
        end
        ST_NMX: begin
          if (ser_done) begin
            nx_q <= renorm(ser_res[93:30], nx_q[31]);
            st_q <= ST_NMY;
            go_q <= 1'b1;
          end
        end
        ST_NMY: begin
          if (ser_done) begin
            ny_q <= renorm(ser_res[93:30], ny_q[31]);
            st_q <= ST_OMUL;
            go_q <= 1'b1;
          end
        end
        ST_OMUL: begin
          if (ser_done) begin
            if (ny_q[31]) begin
              samp_q <= (om_mag > 64'd8388608) ? 24'sh80_0000 : -$signed(om_mag[23:0]);
            end else begin
              samp_q <= (om_mag > 64'd8388607) ? 24'sh7F_FFFF : $signed(om_mag[23:0]);
            end
            st_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ov_q || result_out.ready) begin
            ov_q     <= 1'b1;
            sample_q <= samp_q;
            x_q      <= nx_q;
            y_q      <= ny_q;
            st_q     <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign item_in.ready     = (st_q == ST_IDLE);
  assign result_out.valid  = ov_q;
  assign result_out.sample = sample_q;

  a_done_in_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_done |-> (st_q != ST_IDLE && st_q != ST_OUT)) else $error("serial result without a job");

  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(st_q) == ST_OUT) else $error("output beat raised outside hand-off");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntLast) else $error("renormalization counter out of range");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_TMS || st_q == ST_TDS || st_q == ST_TMC || st_q == ST_TDC)
      |-> (k_q >= 4'd1 && k_q <= 4'd10)) else $error("series term index out of range");

endmodule
